// ===== rtl/core/scpd_pkg.sv =====
// Shared types and constants for the spectrum column peak decimator.
// No dependencies; imported by scpd_column_ctl and the top level.
package scpd_pkg;

  // Default sizes; both are expected to be powers of two.
  localparam int unsigned MAX_BINS_DEF    = 65536;
  localparam int unsigned MAX_COLUMNS_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_BIN       = 3'd0,
    CFG_COLUMN_COUNT    = 3'd1,
    CFG_BINS_PER_COLUMN = 3'd2,
    CFG_REMAINDER_BINS  = 3'd3,
    CFG_HEIGHT_SCALE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] first_bin;
    logic [12:0] column_count;
    logic [15:0] bins_per_column;
    logic [11:0] remainder_bins;
    logic [15:0] height_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_bin:       16'd0,
    column_count:    13'd1024,
    bins_per_column: 16'd1,
    remainder_bins:  12'd0,
    height_scale:    16'd256
  };

  // Column tracker status toward the top level
  typedef struct packed {
    logic        hit;          // next bin lands on the column boundary
    logic [11:0] column_idx;
    logic [16:0] end_bin;
  } col_pos_t;

  // dB constants, signed Q8.8
  localparam logic signed [17:0] PEAK_FLOOR_Q88    = -18'sd37120; // -145 dB
  localparam logic signed [18:0] HEIGHT_OFFSET_Q88 = 19'sd30720;  // +120 dB
  localparam logic signed [18:0] FLOOR_DIFF_Q88    = -19'sd6400;  // floor + 120 dB

endpackage

// ===== rtl/core/scpd_column_ctl.sv =====
// Column boundary tracker: bin counter, next boundary, column and extra-bin
// bookkeeping. Depends on scpd_pkg.
module scpd_column_ctl #(
  parameter int unsigned MAX_BINS    = scpd_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_COLUMNS = scpd_pkg::MAX_COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,     // one bin consumed
  input  logic              last_i,     // that bin ends the frame
  input  logic              restart_i,  // register write
  input  scpd_pkg::cfg_t    cfg_i,      // current registers
  input  scpd_pkg::cfg_t    cfg_nxt_i,  // registers after this cycle's write
  output scpd_pkg::col_pos_t pos_o
);
  import scpd_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_BINS) + 1;   // counts wrap at 2*MAX_BINS
  localparam int unsigned CLW  = $clog2(MAX_COLUMNS);
  localparam int unsigned PW   = CLW + 12;               // (column+1)*remainder
  localparam int unsigned QW   = 25;                     // column_count*(extras+1)
  localparam int unsigned CMPW = (PW > QW) ? PW : QW;
  localparam int unsigned EBW  = (CW > 17) ? CW : 17;

  logic [CW-1:0]  bin_count_r;
  logic [CW-1:0]  boundary_r;
  logic [CLW-1:0] column_r;
  logic [11:0]    extras_r;
  logic [PW-1:0]  prod_col_r;   // running (column+1)*remainder
  logic [QW-1:0]  prod_ext_r;   // running column_count*(extras+1)

  logic [CW-1:0]  bin_inc;
  logic           hit;
  logic           extra;
  logic [CW-1:0]  step_len;
  logic           do_restart;
  cfg_t           rcfg;
  logic [EBW-1:0] end_sum;

  assign bin_inc  = bin_count_r + 1'b1;
  assign hit      = (bin_inc == boundary_r);
  assign extra    = (cfg_i.remainder_bins != '0) &&
                    (CMPW'(prod_col_r) > CMPW'(prod_ext_r));
  assign step_len = CW'(cfg_i.bins_per_column) + CW'(extra);

  assign do_restart = !rst_n || restart_i || (step_i && last_i);
  assign rcfg       = !rst_n ? CFG_RESET : (restart_i ? cfg_nxt_i : cfg_i);

  always_ff @(posedge clk) begin
    if (do_restart) begin
      bin_count_r <= '0;
      boundary_r  <= CW'(rcfg.bins_per_column);
      column_r    <= '0;
      extras_r    <= '0;
      prod_col_r  <= PW'(rcfg.remainder_bins);
      prod_ext_r  <= QW'(rcfg.column_count);
    end else if (step_i) begin
      bin_count_r <= bin_inc;
      if (hit) begin
        boundary_r <= boundary_r + step_len;
        column_r   <= column_r + 1'b1;
        // product tracks the column counter, including its wrap
        if (column_r == {CLW{1'b1}}) begin
          prod_col_r <= PW'(cfg_i.remainder_bins);
        end else begin
          prod_col_r <= prod_col_r + PW'(cfg_i.remainder_bins);
        end
        if (extra) begin
          extras_r <= extras_r + 1'b1;
          if (extras_r == 12'hFFF) begin
            prod_ext_r <= QW'(cfg_i.column_count);
          end else begin
            prod_ext_r <= prod_ext_r + QW'(cfg_i.column_count);
          end
        end
      end
    end
  end

  assign end_sum          = EBW'(cfg_i.first_bin) + EBW'(bin_count_r);
  assign pos_o.hit        = hit;
  assign pos_o.column_idx = 12'(column_r);
  assign pos_o.end_bin    = end_sum[16:0];

endmodule

// ===== rtl/core/spectrum_column_peak_decimator.sv =====
// Top level of the spectrum column peak decimator: handshakes, peak hold,
// bar height. Depends on scpd_pkg and scpd_column_ctl.
//
//   channel | ports                         | direction | word
//   in      | in_valid/in_stall, in_*       | sink      | one spectrum bin
//   out     | out_valid/out_stall, out_*    | source    | one closed column
//   cfg     | cfg_we, cfg_index, cfg_wdata  | sink      | one register write
//
// One bin per clock sustained while no closing bin is held by out_stall.
// A bin in the input register is folded into the running peak, and a
// closing bin loads the output register at the next edge.
// The output register plus the input register give one word of slack: a
// bin is still taken while a result waits under out_stall.
// Reset (rst_n low, synchronous) empties both registers and restarts the
// frame; a write to a known register index restarts the frame too.
module spectrum_column_peak_decimator #(
  parameter int unsigned MAX_BINS    = scpd_pkg::MAX_BINS_DEF,    // power of two
  parameter int unsigned MAX_COLUMNS = scpd_pkg::MAX_COLUMNS_DEF  // power of two
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input bins
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [17:0]             in_level_db,
  input  logic                           in_final_bin,
  // column results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [11:0]                    out_column_index,
  output logic signed [17:0]             out_peak_db,
  output logic [11:0]                    out_bar_height,
  output logic                           out_drawn,
  output logic [16:0]                    out_end_bin,
  output logic                           out_final_column,
  // register writes
  input  logic                           cfg_we,
  input  logic [scpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import scpd_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic cfg_hit;

  always_comb begin
    cfg_nxt = cfg_r;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_BIN: begin
          cfg_nxt.first_bin = cfg_wdata;
          cfg_hit = 1'b1;
        end
        CFG_COLUMN_COUNT: begin
          cfg_nxt.column_count = cfg_wdata[12:0];
          cfg_hit = 1'b1;
        end
        CFG_BINS_PER_COLUMN: begin
          cfg_nxt.bins_per_column = cfg_wdata;
          cfg_hit = 1'b1;
        end
        CFG_REMAINDER_BINS: begin
          cfg_nxt.remainder_bins = cfg_wdata[11:0];
          cfg_hit = 1'b1;
        end
        CFG_HEIGHT_SCALE: begin
          cfg_nxt.height_scale = cfg_wdata;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- input register ----------------
  logic                v1_r;
  logic signed [17:0]  level1_r;
  logic signed [18:0]  ldiff1_r;   // level + 120 dB, precomputed
  logic                final1_r;

  logic in_take;
  logic proc;       // bin in the input register is consumed this cycle
  logic close;
  col_pos_t pos;

  assign in_stall = v1_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_take) begin
      v1_r <= 1'b1;
    end else if (proc) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      level1_r <= in_level_db;
      final1_r <= in_final_bin;
      ldiff1_r <= {in_level_db[17], in_level_db} + HEIGHT_OFFSET_Q88;
    end
  end

  // ---------------- column tracking ----------------
  scpd_column_ctl #(
    .MAX_BINS    (MAX_BINS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_column_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (proc),
    .last_i    (final1_r),
    .restart_i (cfg_hit),
    .cfg_i     (cfg_r),
    .cfg_nxt_i (cfg_nxt),
    .pos_o     (pos)
  );

  assign close = final1_r || pos.hit;
  // a bin that closes nothing needs no room in the output register
  assign proc  = v1_r && (!close || !out_valid || !out_stall);

  // ---------------- peak hold ----------------
  logic signed [17:0] rp_r;     // running peak
  logic signed [18:0] rdiff_r;  // running peak + 120 dB
  logic               gt;
  logic signed [17:0] peak;
  logic signed [18:0] diff;

  assign gt   = level1_r > rp_r;
  assign peak = gt ? level1_r : rp_r;
  assign diff = gt ? ldiff1_r : rdiff_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit || (proc && close)) begin
      rp_r    <= PEAK_FLOOR_Q88;
      rdiff_r <= FLOOR_DIFF_Q88;
    end else if (proc) begin
      rp_r    <= peak;
      rdiff_r <= diff;
    end
  end

  // ---------------- bar height ----------------
  // drawn when peak > -120 dB, i.e. diff > 0; height = diff*scale >> 16, saturated at 0xFFF
  logic        drawn;
  logic [33:0] prod;
  logic [11:0] height;

  assign drawn  = !diff[18] && (diff != '0);
  assign prod   = 34'(diff[17:0]) * 34'(cfg_r.height_scale);
  assign height = !drawn ? 12'd0 : ((|prod[33:28]) ? 12'hFFF : prod[27:16]);

  // ---------------- output register ----------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && close) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && close) begin
      out_column_index <= pos.column_idx;
      out_peak_db      <= peak;
      out_bar_height   <= height;
      out_drawn        <= drawn;
      out_end_bin      <= pos.end_bin;
      out_final_column <= final1_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  // a result appears only from a closing bin
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(proc && close))
    else $error("result without closing bin");

  // peak hold restarts after each closed column
  a_peak_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && close) |=> (rp_r == PEAK_FLOOR_Q88))
    else $error("running peak not restarted");

  // frame end sends the next bin to column zero
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && final1_r) |=> (pos.column_idx == 12'd0))
    else $error("column not restarted after final bin");

  // undrawn column has no bar
  a_undrawn_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_drawn) |-> (out_bar_height == 12'd0))
    else $error("bar height on undrawn column");

endmodule
